// ===== rtl/pmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants for the pub/sub multicast table.
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int ENDPOINTS     = 8;
    localparam int TABLE_ENTRIES = 64;

    localparam logic [2:0] FN_PUBLISH = 3'd0;
    localparam logic [2:0] FN_RELEASE = 3'd1;
    localparam logic [2:0] FN_HEADER  = 3'd2;
    localparam logic [2:0] FN_UNSUB   = 3'd3;
    localparam logic [2:0] FN_SUB     = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOOKUP,
        OP_DROP,
        OP_UNSUB,
        OP_SUB_SCAN,
        OP_CLAIM
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLAIM
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  sender;
        logic [31:0] message_id;
        logic [31:0] instance_id;
        logic        subscribe_all;
        logic        unsubscribe_all;
    } t_in;

    typedef struct packed {
        logic [ENDPOINTS-1:0] dest_mask;
        logic [1:0]           status;
    } t_out;

    // word that travels along the row of cells
    typedef struct packed {
        logic                 vld;
        t_op                  op;
        logic [ENDPOINTS-1:0] sbit;
        logic [63:0]          key;
        logic                 hit;
        logic                 free;
        logic [ENDPOINTS-1:0] acc;
    } t_tok;

endpackage

// ===== rtl/pmt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_cell
// One table entry: key, subscriber mask and valid flag, acting on the word
// that passes through and handing it on in the next cycle.
// ----------------------------------------------------------------------------
module pmt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pmt_pkg::t_tok i_tok,
    output pmt_pkg::t_tok o_tok
);

    logic                          r_valid;
    logic                          n_valid;
    logic [63:0]                   r_key;
    logic [63:0]                   n_key;
    logic [pmt_pkg::ENDPOINTS-1:0] r_mask;
    logic [pmt_pkg::ENDPOINTS-1:0] n_mask;
    pmt_pkg::t_tok                 r_tok;
    pmt_pkg::t_tok                 n_tok;
    logic                          match;

    assign match = r_valid && (r_key == i_tok.key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_mask  = r_mask;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            case (i_tok.op)
                pmt_pkg::OP_LOOKUP: begin
                    if (match) n_tok.acc = i_tok.acc | r_mask;
                end
                pmt_pkg::OP_DROP: begin
                    n_mask = r_mask & ~i_tok.sbit;
                end
                pmt_pkg::OP_UNSUB: begin
                    if (match) n_mask = r_mask & ~i_tok.sbit;
                end
                pmt_pkg::OP_SUB_SCAN: begin
                    if (match) begin
                        n_mask    = r_mask | i_tok.sbit;
                        n_tok.hit = 1'b1;
                    end
                    if (!r_valid) n_tok.free = 1'b1;
                end
                pmt_pkg::OP_CLAIM: begin
                    if (!i_tok.hit && !r_valid) begin
                        n_valid   = 1'b1;
                        n_key     = i_tok.key;
                        n_mask    = i_tok.sbit;
                        n_tok.hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_mask    <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_mask    <= n_mask;
            r_tok.vld <= n_tok.vld;
        end
        r_tok.op   <= n_tok.op;
        r_tok.sbit <= n_tok.sbit;
        r_tok.key  <= n_tok.key;
        r_tok.hit  <= n_tok.hit;
        r_tok.free <= n_tok.free;
        r_tok.acc  <= n_tok.acc;
        r_key      <= n_key;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/pmt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_ctrl
// Command sequencer: catch-all mask, list enable, word launch into the
// cell row and result formation from the word leaving the row.
// ----------------------------------------------------------------------------
module pmt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pmt_pkg::t_in  i_item,
    input  pmt_pkg::t_tok i_tail,
    output logic          o_busy,
    output pmt_pkg::t_tok o_inj,
    output logic          o_done,
    output pmt_pkg::t_out o_result
);

    pmt_pkg::t_state               r_state;
    pmt_pkg::t_state               n_state;
    logic [pmt_pkg::ENDPOINTS-1:0] r_ca;
    logic [pmt_pkg::ENDPOINTS-1:0] n_ca;
    logic                          r_le;
    logic                          n_le;
    logic [1:0]                    r_status;
    logic [1:0]                    n_status;
    pmt_pkg::t_tok                 r_inj;
    pmt_pkg::t_tok                 n_inj;
    logic                          r_done;
    logic                          n_done;
    pmt_pkg::t_out                 r_result;
    pmt_pkg::t_out                 n_result;
    logic [pmt_pkg::ENDPOINTS-1:0] sbit;
    logic [pmt_pkg::ENDPOINTS-1:0] ca_hdr;

    always_comb begin
        for (int e = 0; e < pmt_pkg::ENDPOINTS; e++) begin
            sbit[e] = (int'(i_item.sender) == e);
        end
    end

    assign ca_hdr = i_item.unsubscribe_all ? (r_ca & ~sbit) : r_ca;

    always_comb begin
        n_state  = r_state;
        n_ca     = r_ca;
        n_le     = r_le;
        n_status = r_status;
        n_done   = 1'b0;
        n_result = r_result;
        n_inj      = r_inj;
        n_inj.vld  = 1'b0;
        case (r_state)
            pmt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_inj.vld  = 1'b1;
                    n_inj.op   = pmt_pkg::OP_NOP;
                    n_inj.sbit = sbit;
                    n_inj.key  = {i_item.message_id, i_item.instance_id};
                    n_inj.hit  = 1'b0;
                    n_inj.free = 1'b0;
                    n_inj.acc  = '0;
                    n_status   = pmt_pkg::ST_DONE;
                    n_state    = pmt_pkg::S_SCAN;
                    case (i_item.func)
                        pmt_pkg::FN_PUBLISH: begin
                            n_inj.op = pmt_pkg::OP_LOOKUP;
                        end
                        pmt_pkg::FN_RELEASE: begin
                            n_ca     = r_ca & ~sbit;
                            n_inj.op = pmt_pkg::OP_DROP;
                        end
                        pmt_pkg::FN_HEADER: begin
                            n_ca = ca_hdr;
                            if (|(ca_hdr & sbit)) begin
                                n_le = 1'b0;
                            end else if (i_item.subscribe_all) begin
                                n_inj.op = pmt_pkg::OP_DROP;
                                n_ca     = ca_hdr | sbit;
                                n_le     = 1'b0;
                            end else begin
                                n_le = 1'b1;
                            end
                        end
                        pmt_pkg::FN_UNSUB: begin
                            if (r_le) n_inj.op = pmt_pkg::OP_UNSUB;
                            else      n_status = pmt_pkg::ST_IGNORED;
                        end
                        pmt_pkg::FN_SUB: begin
                            if (r_le) n_inj.op = pmt_pkg::OP_SUB_SCAN;
                            else      n_status = pmt_pkg::ST_IGNORED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pmt_pkg::S_SCAN: begin
                if (i_tail.vld) begin
                    if (i_tail.op == pmt_pkg::OP_SUB_SCAN && !i_tail.hit
                        && i_tail.free) begin
                        n_inj     = i_tail;
                        n_inj.op  = pmt_pkg::OP_CLAIM;
                        n_inj.hit = 1'b0;
                        n_state   = pmt_pkg::S_CLAIM;
                    end else begin
                        n_done             = 1'b1;
                        n_state            = pmt_pkg::S_IDLE;
                        n_result.status    = r_status;
                        n_result.dest_mask = '0;
                        if (i_tail.op == pmt_pkg::OP_SUB_SCAN && !i_tail.hit) begin
                            n_result.status = pmt_pkg::ST_FULL;
                        end
                        if (i_tail.op == pmt_pkg::OP_LOOKUP) begin
                            n_result.dest_mask = (r_ca | i_tail.acc) & ~i_tail.sbit;
                        end
                    end
                end
            end
            pmt_pkg::S_CLAIM: begin
                if (i_tail.vld) begin
                    n_done             = 1'b1;
                    n_state            = pmt_pkg::S_IDLE;
                    n_result.status    = pmt_pkg::ST_DONE;
                    n_result.dest_mask = '0;
                end
            end
            default: begin
                n_state = pmt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pmt_pkg::S_IDLE;
            r_ca      <= '0;
            r_le      <= 1'b0;
            r_done    <= 1'b0;
            r_inj.vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ca      <= n_ca;
            r_le      <= n_le;
            r_done    <= n_done;
            r_inj.vld <= n_inj.vld;
        end
        r_inj.op   <= n_inj.op;
        r_inj.sbit <= n_inj.sbit;
        r_inj.key  <= n_inj.key;
        r_inj.hit  <= n_inj.hit;
        r_inj.free <= n_inj.free;
        r_inj.acc  <= n_inj.acc;
        r_status   <= n_status;
        r_result   <= n_result;
    end

    assign o_busy   = (r_state != pmt_pkg::S_IDLE);
    assign o_inj    = r_inj;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/pubsub_multicast_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pubsub_multicast_table_core
// Pub/sub channel table with catch-all subscribers, built as a row of cells.
// ----------------------------------------------------------------------------
// A command word is taken on i_item at a rising edge where start is high and
// busy is low. One result word per command appears on o_result for a single
// cycle, flagged by o_done; the receiver cannot hold it off.
// Each command is launched as a word into a row of TABLE_ENTRIES cells, one
// per table entry, and moves one cell per cycle. o_done is registered in the
// controller from the word leaving the last cell. A subscribe for a key not
// yet in the table that finds a free entry needs a second pass through the
// row to claim the lowest free entry.
// busy falls with the result cycle, so one command is in flight at a time
// and the next can be taken at the edge that ends the result cycle.
// Reset (synchronous, active low) empties the table, clears the catch-all
// mask and disables subscription lists; keys need no clearing as they are
// only compared in valid entries.
// ----------------------------------------------------------------------------
module pubsub_multicast_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pmt_pkg::t_in  i_item,
    output logic          o_done,
    output pmt_pkg::t_out o_result
);

    pmt_pkg::t_tok w_tok [0:pmt_pkg::TABLE_ENTRIES];

    pmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_tail   (w_tok[pmt_pkg::TABLE_ENTRIES]),
        .o_busy   (busy),
        .o_inj    (w_tok[0]),
        .o_done   (o_done),
        .o_result (o_result)
    );

    for (genvar g = 0; g < pmt_pkg::TABLE_ENTRIES; g++) begin : g_cell
        pmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule

// ===== rtl/pmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks on command and result words of the table core.
// ----------------------------------------------------------------------------
module pmt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input pmt_pkg::t_in  i_item,
    input logic          o_done,
    input pmt_pkg::t_out o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result word repeated");

    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("command finished without a result word");

    a_err_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != pmt_pkg::ST_DONE) |->
        (o_result.dest_mask == '0))
        else $error("error result carries a destination mask");

endmodule

bind pubsub_multicast_table_core pmt_checker u_pmt_checker (.*);

// ===== bench/pubsub_multicast_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pubsub_multicast_table_core_tb
// Self-checking bench for the pub/sub multicast channel table.
// ----------------------------------------------------------------------------
// A short table of directed commands comes first: reset state, key extremes,
// every func code, entries with no header, catch-all headers and release.
// The random part that follows is mostly well-formed requests (header, then
// unsubscribe entries, then subscribe entries) over a small pool of keys. One
// burst of fresh keys fills the table so later subscribes see it full. Each
// result word is checked against a local model of the channel table.
// ----------------------------------------------------------------------------
module pubsub_multicast_table_core_tb;

    localparam int          CLK_HIGH    = 6;
    localparam int          CLK_LOW     = 6;
    localparam int          RST_CYCLES  = 7;
    localparam int          RANDOM_CMDS = 400;
    localparam int          FILL_AT     = 250;
    localparam int          KEY_POOL    = 48;
    localparam int          SETTLE      = 2 * pmt_pkg::TABLE_ENTRIES + 16;
    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [2:0]  FN_SPARE5   = 3'd5;
    localparam logic [2:0]  FN_SPARE7   = 3'd7;
    localparam logic [2:0]  FN_SPARE6   = 3'd6;
    localparam logic [63:0] K_ZERO      = 64'h0;
    localparam logic [63:0] K_ONES      = '1;
    localparam logic [63:0] K_MID       = 64'h12345678_9abcdef0;
    localparam logic [63:0] K_ODD       = 64'hdeadbeef_00000001;

    typedef struct {
        pmt_pkg::t_in  cmd;
        bit            typed;
        pmt_pkg::t_out res;
        bit            drain;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          o_done;
    pmt_pkg::t_in  i_item;
    pmt_pkg::t_out o_result;

    // typed-in expectation travelling with the driven word
    bit            drv_typed;
    pmt_pkg::t_out drv_res;

    logic [63:0]                   chan_key  [pmt_pkg::TABLE_ENTRIES];
    logic [pmt_pkg::ENDPOINTS-1:0] chan_subs [pmt_pkg::TABLE_ENTRIES];
    bit                            chan_live [pmt_pkg::TABLE_ENTRIES];
    logic [pmt_pkg::ENDPOINTS-1:0] catch_all;
    bit                            lists_open;

    t_row          cmd_rows[$];
    pmt_pkg::t_out pending_results[$];
    logic [63:0]   key_pool [KEY_POOL];
    int            mismatches = 0;
    int            cycles     = 0;
    int            calm_left  = 0;

    pubsub_multicast_table_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HIGH;
        i_clk = 1'b0;
        #CLK_LOW;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic pmt_pkg::t_out predict_route(input pmt_pkg::t_in c);
        pmt_pkg::t_out                 r;
        logic [63:0]                   k;
        logic [pmt_pkg::ENDPOINTS-1:0] b;
        int                            hit;
        int                            slot;
        r    = '0;
        k    = {c.message_id, c.instance_id};
        b    = '0;
        hit  = -1;
        slot = -1;
        if (int'(c.sender) < pmt_pkg::ENDPOINTS) begin
            b[c.sender] = 1'b1;
        end
        for (int i = 0; i < pmt_pkg::TABLE_ENTRIES; i++) begin
            if (chan_live[i] && chan_key[i] == k && hit < 0) begin
                hit = i;
            end
            if (!chan_live[i] && slot < 0) begin
                slot = i;
            end
        end
        case (c.func)
            pmt_pkg::FN_PUBLISH: begin
                r.dest_mask = (catch_all | ((hit >= 0) ? chan_subs[hit] : '0)) & ~b;
            end
            pmt_pkg::FN_RELEASE: begin
                catch_all &= ~b;
                for (int i = 0; i < pmt_pkg::TABLE_ENTRIES; i++) chan_subs[i] &= ~b;
            end
            pmt_pkg::FN_HEADER: begin
                if (c.unsubscribe_all) catch_all &= ~b;
                if (b != '0 && (catch_all & b) != '0) begin
                    lists_open = 1'b0;
                end else if (c.subscribe_all) begin
                    for (int i = 0; i < pmt_pkg::TABLE_ENTRIES; i++) chan_subs[i] &= ~b;
                    catch_all |= b;
                    lists_open = 1'b0;
                end else begin
                    lists_open = 1'b1;
                end
            end
            pmt_pkg::FN_UNSUB: begin
                if (!lists_open) begin
                    r.status = pmt_pkg::ST_IGNORED;
                end else if (hit >= 0) begin
                    chan_subs[hit] &= ~b;
                end
            end
            pmt_pkg::FN_SUB: begin
                if (!lists_open) begin
                    r.status = pmt_pkg::ST_IGNORED;
                end else if (hit >= 0) begin
                    chan_subs[hit] |= b;
                end else if (slot >= 0) begin
                    chan_live[slot] = 1'b1;
                    chan_key[slot]  = k;
                    chan_subs[slot] = b;
                end else begin
                    r.status = pmt_pkg::ST_FULL;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 99) < 15) return {$urandom, $urandom};
        return key_pool[$urandom_range(0, KEY_POOL - 1)];
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 96) return $urandom_range(5, 30);
        return $urandom_range(60, 200);
    endfunction

    task automatic add_cmd(input logic [2:0] fn, input logic [2:0] snd,
                           input logic [63:0] key, input logic sa, input logic ua,
                           input bit drain, input bit typed,
                           input logic [pmt_pkg::ENDPOINTS-1:0] dest,
                           input logic [1:0] st);
        t_row row;
        row.cmd.func            = fn;
        row.cmd.sender          = snd;
        row.cmd.message_id      = key[63:32];
        row.cmd.instance_id     = key[31:0];
        row.cmd.subscribe_all   = sa;
        row.cmd.unsubscribe_all = ua;
        row.typed               = typed;
        row.res.dest_mask       = dest;
        row.res.status          = st;
        row.drain               = drain;
        cmd_rows.push_back(row);
    endtask

    always @(posedge i_clk) begin : result_check
        pmt_pkg::t_out want;
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %02h/%0d",
                             $time, o_result.dest_mask, o_result.status);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.dest_mask !== want.dest_mask) begin
                        $display("%0t dest_mask: expected %02h, actual %02h",
                                 $time, want.dest_mask, o_result.dest_mask);
                        mismatches++;
                    end
                    if (o_result.status !== want.status) begin
                        $display("%0t status: expected %0d, actual %0d",
                                 $time, want.status, o_result.status);
                        mismatches++;
                    end
                end
            end else if (o_done !== 1'b0) begin
                $display("%0t o_done: expected 0/1, actual %b", $time, o_done);
                mismatches++;
            end
            if (start === 1'b1 && busy === 1'b0) begin
                want = predict_route(i_item);
                if (drv_typed) want = drv_res;
                pending_results.push_back(want);
            end
        end
    end

    initial begin : main
        int         gap;
        int         n_rand;
        int         r;
        int         nu;
        int         ns;
        bit         filled;
        bit         hold;
        logic [2:0] snd;
        logic [2:0] fn;

        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_item    <= '0;
        drv_typed <= 1'b0;
        drv_res   <= '0;

        for (int i = 0; i < pmt_pkg::TABLE_ENTRIES; i++) begin
            chan_key[i]  = '0;
            chan_subs[i] = '0;
            chan_live[i] = 1'b0;
        end
        catch_all  = '0;
        lists_open = 1'b0;

        // odd pool keys above index 1 share the message id of their lower neighbour
        key_pool[0] = K_ZERO;
        key_pool[1] = K_ONES;
        for (int k = 2; k < KEY_POOL; k++) begin
            key_pool[k] = (k % 2) ? {key_pool[k - 1][63:32], $urandom} : {$urandom, $urandom};
        end

        add_cmd(pmt_pkg::FN_PUBLISH, 3'd0, K_ZERO, 1'b0, 1'b0, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_UNSUB,   3'd7, K_ONES, 1'b1, 1'b1, 1'b0, 1'b1,
                '0, pmt_pkg::ST_IGNORED);
        add_cmd(pmt_pkg::FN_SUB,     3'd7, K_ONES, 1'b1, 1'b1, 1'b0, 1'b1,
                '0, pmt_pkg::ST_IGNORED);
        add_cmd(FN_SPARE5,           3'd1, K_MID,  1'b0, 1'b1, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(FN_SPARE6,           3'd2, K_MID,  1'b1, 1'b0, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(FN_SPARE7,           3'd7, K_ONES, 1'b1, 1'b1, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_HEADER,  3'd3, K_ZERO, 1'b0, 1'b0, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_SUB,     3'd3, K_ZERO, 1'b0, 1'b0, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_SUB,     3'd5, K_ONES, 1'b0, 1'b0, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_SUB,     3'd0, K_ONES, 1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_PUBLISH, 3'd0, K_ZERO, 1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_PUBLISH, 3'd3, K_ZERO, 1'b1, 1'b1, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_PUBLISH, 3'd7, K_ONES, 1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_UNSUB,   3'd3, K_ZERO, 1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_UNSUB,   3'd4, K_MID,  1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_HEADER,  3'd6, K_ODD,  1'b1, 1'b0, 1'b1, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_PUBLISH, 3'd0, K_MID,  1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_SUB,     3'd2, K_ODD,  1'b0, 1'b0, 1'b0, 1'b1,
                '0, pmt_pkg::ST_IGNORED);
        add_cmd(pmt_pkg::FN_HEADER,  3'd6, K_ZERO, 1'b1, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_HEADER,  3'd6, K_ZERO, 1'b1, 1'b1, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_HEADER,  3'd6, K_ZERO, 1'b0, 1'b1, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_SUB,     3'd6, K_ONES, 1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_PUBLISH, 3'd6, K_ONES, 1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_RELEASE, 3'd5, K_MID,  1'b1, 1'b1, 1'b0, 1'b1,
                '0, pmt_pkg::ST_DONE);
        add_cmd(pmt_pkg::FN_PUBLISH, 3'd7, K_ONES, 1'b0, 1'b0, 1'b0, 1'b0,
                '0, pmt_pkg::ST_DONE);

        n_rand = 0;
        filled = 1'b0;
        while (n_rand < RANDOM_CMDS) begin
            if (!filled && n_rand >= FILL_AT) begin
                // fresh keys until the table runs out of entries
                filled = 1'b1;
                snd    = 3'($urandom_range(0, 7));
                add_cmd(pmt_pkg::FN_HEADER, snd, pick_key(), 1'b0, 1'b1,
                        1'b1, 1'b0, '0, pmt_pkg::ST_DONE);
                repeat (pmt_pkg::TABLE_ENTRIES + 8) begin
                    add_cmd(pmt_pkg::FN_SUB, snd, {$urandom, $urandom},
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'b0, 1'b0, '0, pmt_pkg::ST_DONE);
                end
                n_rand += pmt_pkg::TABLE_ENTRIES + 9;
            end
            r   = $urandom_range(0, 99);
            snd = 3'($urandom_range(0, 7));
            if (r < 50) begin
                nu = $urandom_range(0, 3);
                ns = $urandom_range(1, 5);
                add_cmd(pmt_pkg::FN_HEADER, snd, pick_key(), $urandom_range(0, 9) == 0,
                        1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0, 1'b0,
                        '0, pmt_pkg::ST_DONE);
                repeat (nu) begin
                    add_cmd(pmt_pkg::FN_UNSUB, snd, pick_key(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b0, 1'b0, '0, pmt_pkg::ST_DONE);
                end
                repeat (ns) begin
                    add_cmd(pmt_pkg::FN_SUB, snd, pick_key(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b0, 1'b0, '0, pmt_pkg::ST_DONE);
                end
                n_rand += 1 + nu + ns;
            end else begin
                if (r < 75) fn = pmt_pkg::FN_PUBLISH;
                else if (r < 82) fn = pmt_pkg::FN_RELEASE;
                else if (r < 89) fn = pmt_pkg::FN_HEADER;
                else if (r < 96) begin
                    fn = ($urandom_range(0, 1) != 0) ? pmt_pkg::FN_UNSUB : pmt_pkg::FN_SUB;
                end
                else fn = 3'($urandom_range(FN_SPARE5, FN_SPARE7));
                add_cmd(fn, snd, pick_key(),
                        (fn == pmt_pkg::FN_HEADER) ? 1'b1 : 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0, 1'b0,
                        '0, pmt_pkg::ST_DONE);
                if (fn <= pmt_pkg::FN_SUB) n_rand++;
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap = 0;
        for (int i = 0; i < cmd_rows.size(); i++) begin
            hold = (gap == 0) && !cmd_rows[i].drain;
            if (!hold) begin
                if (cmd_rows[i].drain) begin
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                repeat (gap) @(posedge i_clk);
            end
            start     <= 1'b1;
            i_item    <= cmd_rows[i].cmd;
            drv_typed <= cmd_rows[i].typed;
            drv_res   <= cmd_rows[i].res;
            @(posedge i_clk);
            while (busy !== 1'b0) @(posedge i_clk);
            gap = pick_gap();
            if (i + 1 == cmd_rows.size() || gap != 0 || cmd_rows[i + 1].drain) begin
                start <= 1'b0;
            end
        end

        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t missing results: expected 0 pending, actual %0d",
                     $time, pending_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pmt_pkg.sv
rtl/pmt_cell.sv
rtl/pmt_ctrl.sv
rtl/pubsub_multicast_table_core.sv
rtl/pmt_checker.sv
bench/pubsub_multicast_table_core_tb.sv
